>>> src/polarimetric_basis_change_defines.svh
// Assertion macros for the polarimetric basis change block.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef POLARIMETRIC_BASIS_CHANGE_DEFINES_SVH
`define POLARIMETRIC_BASIS_CHANGE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PBC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pbc assertion failed");

// Next-cycle implication, disabled in reset.
`define PBC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pbc assertion failed");

`endif

>>> src/pbc_pkg.sv
// Shared constants, codes and trig helpers for the polarimetric basis change.
// No dependencies.
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int TRIG_W           = 18;
  localparam int TRIG_FRAC        = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int NUM_STAGES       = 5;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_MODE  = 3'd0,
    CFG_COS_ORIENT = 3'd1,
    CFG_SIN_ORIENT = 3'd2,
    CFG_COS_ELLIP  = 3'd3,
    CFG_SIN_ELLIP  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MODE_SINCLAIR  = 1'b0,
    MODE_COHERENCY = 1'b1
  } mode_t;

  // Clamp a raw register to +-1.0.
  function automatic logic signed [TRIG_W-1:0] trig_clamp(input logic signed [TRIG_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    r = v;
    if (v > TRIG_ONE) r = TRIG_ONE;
    if (v < -TRIG_ONE) r = -TRIG_ONE;
    return r;
  endfunction

  // Rounded product of two clamped trig values, half toward plus infinity.
  function automatic logic signed [TRIG_W-1:0] trig_mul(input logic signed [TRIG_W-1:0] a,
                                                        input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b + (2*TRIG_W)'(1 << (TRIG_FRAC-1));
    return p[TRIG_FRAC +: TRIG_W];
  endfunction

endpackage

>>> src/polarimetric_basis_change.sv
// Polarimetric basis change: five-stage pipeline, Sinclair 2x2 or coherency 3x3 pixels.
// Depends on pbc_pkg and polarimetric_basis_change_defines.svh.
//
// Takes one pixel per clock while the output is not stalled. The rate is set
// by two fully parallel banks of rounding multipliers (one per matrix product term), each
// followed by an adder/saturation stage; every stage has its own valid bit and a stalled
// output backs up only the stages that are full. The basis matrices are rebuilt from the
// configuration registers in one registered step, so a write takes effect for pixels
// accepted from the next cycle on; pixels already in the pipeline can see it as well.
`timescale 1ns / 1ps
`include "polarimetric_basis_change_defines.svh"

module polarimetric_basis_change #(
  parameter int SAMPLE_WIDTH = pbc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbc_pkg::TRIG_W-1:0]           cfg_wdata,
  input  logic                                 in_vld,
  output logic                                 in_ready,
  input  logic                                 in_pixel_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_a,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_b,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_c,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_d,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_e,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_f,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_g,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_h,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_elem_i,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_a,
  output logic signed [SAMPLE_WIDTH-1:0]       out_b,
  output logic signed [SAMPLE_WIDTH-1:0]       out_c,
  output logic signed [SAMPLE_WIDTH-1:0]       out_d,
  output logic signed [SAMPLE_WIDTH-1:0]       out_e,
  output logic signed [SAMPLE_WIDTH-1:0]       out_f,
  output logic signed [SAMPLE_WIDTH-1:0]       out_g,
  output logic signed [SAMPLE_WIDTH-1:0]       out_h,
  output logic signed [SAMPLE_WIDTH-1:0]       out_i
);

  localparam int TW    = pbc_pkg::TRIG_W;
  localparam int TF    = pbc_pkg::TRIG_FRAC;
  localparam int NS    = pbc_pkg::NUM_STAGES;
  localparam int XW    = SAMPLE_WIDTH + 1;   // holds negated samples
  localparam int PW1   = SAMPLE_WIDTH + 2;
  localparam int SUM1W = SAMPLE_WIDTH + 5;
  localparam int M1W   = SAMPLE_WIDTH + 4;
  localparam int PW2   = SAMPLE_WIDTH + 5;
  localparam int SUM2W = SAMPLE_WIDTH + 8;
  localparam int PR1W  = XW + TW;
  localparam int PR2W  = M1W + TW;
  localparam logic signed [PR1W-1:0] RND1 = PR1W'(1) <<< (TF-1);
  localparam logic signed [PR2W-1:0] RND2 = PR2W'(1) <<< (TF-1);

  function automatic logic signed [PW1-1:0] mul1(input logic signed [XW-1:0] x,
                                                 input logic signed [TW-1:0] u);
    logic signed [PR1W-1:0] p;
    p = x * u + RND1;
    return p[TF +: PW1];
  endfunction

  function automatic logic signed [PW2-1:0] mul2(input logic signed [M1W-1:0] x,
                                                 input logic signed [TW-1:0] u);
    logic signed [PR2W-1:0] p;
    p = x * u + RND2;
    return p[TF +: PW2];
  endfunction

  function automatic logic signed [M1W-1:0] sat1(input logic signed [SUM1W-1:0] s);
    logic signed [M1W-1:0] r;
    if (s[SUM1W-1:M1W-1] == '0 || s[SUM1W-1:M1W-1] == '1) begin
      r = s[M1W-1:0];
    end else begin
      r = {s[SUM1W-1], {(M1W-1){~s[SUM1W-1]}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat2(input logic signed [SUM2W-1:0] s);
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (s[SUM2W-1:SAMPLE_WIDTH-1] == '0 || s[SUM2W-1:SAMPLE_WIDTH-1] == '1) begin
      r = s[SAMPLE_WIDTH-1:0];
    end else begin
      r = {s[SUM2W-1], {(SAMPLE_WIDTH-1){~s[SUM2W-1]}}};
    end
    return r;
  endfunction

  // ---------------- configuration ----------------
  pbc_pkg::mode_t          mode_r;
  logic signed [TW-1:0]    co_r, so_r, ce_r, se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pbc_pkg::MODE_SINCLAIR;
      co_r   <= pbc_pkg::TRIG_ONE;
      so_r   <= '0;
      ce_r   <= pbc_pkg::TRIG_ONE;
      se_r   <= '0;
    end else if (cfg_we) begin
      case (pbc_pkg::cfg_idx_t'(cfg_index))
        pbc_pkg::CFG_DATA_MODE:  mode_r <= pbc_pkg::mode_t'(cfg_wdata[0]);
        pbc_pkg::CFG_COS_ORIENT: co_r   <= cfg_wdata;
        pbc_pkg::CFG_SIN_ORIENT: so_r   <= cfg_wdata;
        pbc_pkg::CFG_COS_ELLIP:  ce_r   <= cfg_wdata;
        pbc_pkg::CFG_SIN_ELLIP:  se_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficients of the first (p) and second (q) product.
  logic signed [TW-1:0] p_re_r [3][3], p_im_r [3][3], q_re_r [3][3], q_im_r [3][3];
  logic signed [TW-1:0] p_re_nxt [3][3], p_im_nxt [3][3], q_re_nxt [3][3], q_im_nxt [3][3];

  always_comb begin
    logic signed [TW-1:0] co, so, ce, se, cc, ss, sc, cs;
    logic signed [TW-1:0] ur [3][3];
    logic signed [TW-1:0] ui [3][3];
    co = pbc_pkg::trig_clamp(co_r);
    so = pbc_pkg::trig_clamp(so_r);
    ce = pbc_pkg::trig_clamp(ce_r);
    se = pbc_pkg::trig_clamp(se_r);
    cc = pbc_pkg::trig_mul(co, ce);
    ss = pbc_pkg::trig_mul(so, se);
    sc = pbc_pkg::trig_mul(so, ce);
    cs = pbc_pkg::trig_mul(co, se);
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ur[a][b] = '0;
        ui[a][b] = '0;
      end
    end
    if (mode_r == pbc_pkg::MODE_SINCLAIR) begin
      ur[0][0] = cc;  ui[0][0] = -ss;
      ur[0][1] = -sc; ui[0][1] = cs;
      ur[1][0] = sc;  ui[1][0] = cs;
      ur[1][1] = cc;  ui[1][1] = ss;
    end else begin
      ur[0][0] = ce;
      ui[0][1] = -ss;
      ui[0][2] = cs;
      ur[1][1] = co;
      ur[1][2] = so;
      ui[2][0] = se;
      ur[2][1] = -sc;
      ur[2][2] = cc;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (mode_r == pbc_pkg::MODE_SINCLAIR) begin
          // U^T S U
          p_re_nxt[a][b] = ur[b][a];
          p_im_nxt[a][b] = ui[b][a];
          q_re_nxt[a][b] = ur[a][b];
          q_im_nxt[a][b] = ui[a][b];
        end else begin
          // U T U^H
          p_re_nxt[a][b] = ur[a][b];
          p_im_nxt[a][b] = ui[a][b];
          q_re_nxt[a][b] = ur[b][a];
          q_im_nxt[a][b] = -ui[b][a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_re_r <= p_re_nxt;
    p_im_r <= p_im_nxt;
    q_re_r <= q_re_nxt;
    q_im_r <= q_im_nxt;
  end

  // ---------------- pipeline control ----------------
  logic [NS:1]   v_r;
  logic [NS+1:1] rdy;
  pbc_pkg::mode_t m_r [NS-1:1];

  always_comb begin
    rdy[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1] && rst_n;
  assign out_valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_vld;
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) m_r[1] <= mode_r;
    for (int k = 2; k <= NS-1; k++) begin
      if (rdy[k]) m_r[k] <= m_r[k-1];
    end
  end

  // ---------------- stage 1: pixel matrix ----------------
  logic signed [XW-1:0] x_re_r [3][3], x_im_r [3][3];
  logic signed [XW-1:0] x_re_nxt [3][3], x_im_nxt [3][3];

  always_comb begin
    logic signed [XW-1:0] ea, eb, ec, ed, ee, ef, eg, eh, ei;
    ea = XW'(in_elem_a); eb = XW'(in_elem_b); ec = XW'(in_elem_c);
    ed = XW'(in_elem_d); ee = XW'(in_elem_e); ef = XW'(in_elem_f);
    eg = XW'(in_elem_g); eh = XW'(in_elem_h); ei = XW'(in_elem_i);
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        x_re_nxt[a][b] = '0;
        x_im_nxt[a][b] = '0;
      end
    end
    // an invalid pixel enters as zeros and leaves as zeros
    if (in_pixel_valid) begin
      if (mode_r == pbc_pkg::MODE_SINCLAIR) begin
        x_re_nxt[0][0] = ea; x_im_nxt[0][0] = eb;
        x_re_nxt[0][1] = ec; x_im_nxt[0][1] = ed;
        x_re_nxt[1][0] = ee; x_im_nxt[1][0] = ef;
        x_re_nxt[1][1] = eg; x_im_nxt[1][1] = eh;
      end else begin
        x_re_nxt[0][0] = ea;
        x_re_nxt[0][1] = eb; x_im_nxt[0][1] = ec;
        x_re_nxt[0][2] = ed; x_im_nxt[0][2] = ee;
        x_re_nxt[1][1] = ef;
        x_re_nxt[1][2] = eg; x_im_nxt[1][2] = eh;
        x_re_nxt[2][2] = ei;
        x_re_nxt[1][0] = eb; x_im_nxt[1][0] = -ec;
        x_re_nxt[2][0] = ed; x_im_nxt[2][0] = -ee;
        x_re_nxt[2][1] = eg; x_im_nxt[2][1] = -eh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x_re_r <= x_re_nxt;
      x_im_r <= x_im_nxt;
    end
  end

  // ---------------- stage 2: first product terms ----------------
  // term [a][k][i] = x[i][k] * p[a][i]
  logic signed [PW1-1:0] t1_rr_r [3][3][3], t1_ii_r [3][3][3];
  logic signed [PW1-1:0] t1_ri_r [3][3][3], t1_ir_r [3][3][3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          for (int i = 0; i < 3; i++) begin
            t1_rr_r[a][k][i] <= mul1(x_re_r[i][k], p_re_r[a][i]);
            t1_ii_r[a][k][i] <= mul1(x_im_r[i][k], p_im_r[a][i]);
            t1_ri_r[a][k][i] <= mul1(x_re_r[i][k], p_im_r[a][i]);
            t1_ir_r[a][k][i] <= mul1(x_im_r[i][k], p_re_r[a][i]);
          end
        end
      end
    end
  end

  // ---------------- stage 3: first product sums ----------------
  logic signed [M1W-1:0] m1_re_r [3][3], m1_im_r [3][3];
  logic signed [M1W-1:0] m1_re_nxt [3][3], m1_im_nxt [3][3];

  always_comb begin
    logic signed [SUM1W-1:0] sr, si;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        sr = '0;
        si = '0;
        for (int i = 0; i < 3; i++) begin
          sr = sr + SUM1W'(t1_rr_r[a][k][i]) - SUM1W'(t1_ii_r[a][k][i]);
          si = si + SUM1W'(t1_ri_r[a][k][i]) + SUM1W'(t1_ir_r[a][k][i]);
        end
        m1_re_nxt[a][k] = sat1(sr);
        m1_im_nxt[a][k] = sat1(si);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      m1_re_r <= m1_re_nxt;
      m1_im_r <= m1_im_nxt;
    end
  end

  // ---------------- stage 4: second product terms ----------------
  // term [a][b][k] = m1[a][k] * q[k][b]
  logic signed [PW2-1:0] t2_rr_r [3][3][3], t2_ii_r [3][3][3];
  logic signed [PW2-1:0] t2_ri_r [3][3][3], t2_ir_r [3][3][3];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int k = 0; k < 3; k++) begin
            t2_rr_r[a][b][k] <= mul2(m1_re_r[a][k], q_re_r[k][b]);
            t2_ii_r[a][b][k] <= mul2(m1_im_r[a][k], q_im_r[k][b]);
            t2_ri_r[a][b][k] <= mul2(m1_re_r[a][k], q_im_r[k][b]);
            t2_ir_r[a][b][k] <= mul2(m1_im_r[a][k], q_re_r[k][b]);
          end
        end
      end
    end
  end

  // ---------------- stage 5: second sums, output layout ----------------
  logic signed [SAMPLE_WIDTH-1:0] o_nxt [9];
  logic signed [SAMPLE_WIDTH-1:0] o_r   [9];

  always_comb begin
    logic signed [SUM2W-1:0] sr, si;
    logic signed [SAMPLE_WIDTH-1:0] yr [3][3];
    logic signed [SAMPLE_WIDTH-1:0] yi [3][3];
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        sr = '0;
        si = '0;
        for (int k = 0; k < 3; k++) begin
          sr = sr + SUM2W'(t2_rr_r[a][b][k]) - SUM2W'(t2_ii_r[a][b][k]);
          si = si + SUM2W'(t2_ri_r[a][b][k]) + SUM2W'(t2_ir_r[a][b][k]);
        end
        yr[a][b] = sat2(sr);
        yi[a][b] = sat2(si);
      end
    end
    if (m_r[4] == pbc_pkg::MODE_SINCLAIR) begin
      o_nxt[0] = yr[0][0]; o_nxt[1] = yi[0][0];
      o_nxt[2] = yr[0][1]; o_nxt[3] = yi[0][1];
      o_nxt[4] = yr[1][0]; o_nxt[5] = yi[1][0];
      o_nxt[6] = yr[1][1]; o_nxt[7] = yi[1][1];
      o_nxt[8] = '0;
    end else begin
      o_nxt[0] = yr[0][0];
      o_nxt[1] = yr[0][1]; o_nxt[2] = yi[0][1];
      o_nxt[3] = yr[0][2]; o_nxt[4] = yi[0][2];
      o_nxt[5] = yr[1][1];
      o_nxt[6] = yr[1][2]; o_nxt[7] = yi[1][2];
      o_nxt[8] = yr[2][2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) o_r <= o_nxt;
  end

  assign out_a = o_r[0];
  assign out_b = o_r[1];
  assign out_c = o_r[2];
  assign out_d = o_r[3];
  assign out_e = o_r[4];
  assign out_f = o_r[5];
  assign out_g = o_r[6];
  assign out_h = o_r[7];
  assign out_i = o_r[8];

  // ---------------- checks ----------------
  `PBC_ASSERT_NOW(a_full_stall_blocks_input, (&v_r) && !out_ready, !in_ready)
  `PBC_ASSERT_NEXT(a_stalled_beat_held, out_valid && !out_ready, out_valid)
  `PBC_ASSERT_NOW(a_stage1_stall_means_full, v_r[1] && !rdy[1], &v_r)

endmodule

>>> test/tb.sv
// Self-checking testbench for polarimetric_basis_change (Sinclair and coherency modes).
// Depends on pbc_pkg and the RTL; predicts every pixel in SystemVerilog and checks each beat.
`timescale 1ns / 1ps

module tb;

  localparam int SW = 32;
  localparam int HOLD_CYCLES = 60;
  localparam logic [pbc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam logic [pbc_pkg::TRIG_W-1:0] TRIG_POS_ONE = 18'h10000;
  localparam logic [pbc_pkg::TRIG_W-1:0] TRIG_NEG_ONE = 18'h30000;
  localparam logic [pbc_pkg::TRIG_W-1:0] TRIG_RAW_MAX = 18'h1ffff;
  localparam logic [pbc_pkg::TRIG_W-1:0] TRIG_RAW_MIN = 18'h20000;
  localparam logic [SW-1:0] S_MAX = 32'h7fffffff;
  localparam logic [SW-1:0] S_MIN = 32'h80000000;

  typedef logic [8:0][SW-1:0] pix_t;
  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [pbc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pbc_pkg::TRIG_W-1:0] cfg_wdata;
  logic in_vld, in_ready, in_pixel_valid;
  pix_t in_elems;
  logic out_valid, out_ready;
  logic signed [SW-1:0] out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h, out_i;

  // shadow copy of the block's registers
  pbc_pkg::mode_t shadow_mode;
  logic [pbc_pkg::TRIG_W-1:0] shadow_co, shadow_so, shadow_ce, shadow_se;

  pix_t pending_pixels[$];
  int errors;
  int in_idle_pct, out_idle_pct;
  bit hold_req;

  polarimetric_basis_change DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_vld(in_vld), .in_ready(in_ready), .in_pixel_valid(in_pixel_valid),
    .in_elem_a(in_elems[0]), .in_elem_b(in_elems[1]), .in_elem_c(in_elems[2]),
    .in_elem_d(in_elems[3]), .in_elem_e(in_elems[4]), .in_elem_f(in_elems[5]),
    .in_elem_g(in_elems[6]), .in_elem_h(in_elems[7]), .in_elem_i(in_elems[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_a(out_a), .out_b(out_b), .out_c(out_c), .out_d(out_d), .out_e(out_e),
    .out_f(out_f), .out_g(out_g), .out_h(out_h), .out_i(out_i)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------- prediction ----------------

  function automatic longint clamp_trig(logic [pbc_pkg::TRIG_W-1:0] r);
    longint v;
    v = longint'($signed(r));
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  // round(x*u / 2^16), half toward plus infinity
  function automatic longint qmul(longint x, longint u);
    return (x * u + 32768) >>> 16;
  endfunction

  function automatic cplx_t cx(longint re, longint im);
    cplx_t r;
    r.re = re;
    r.im = im;
    return r;
  endfunction

  function automatic cplx_t ctimes(cplx_t x, cplx_t u);
    return cx(qmul(x.re, u.re) - qmul(x.im, u.im), qmul(x.re, u.im) + qmul(x.im, u.re));
  endfunction

  function automatic longint clip(longint x, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic pix_t predict_pixel(logic pv, pix_t px);
    cplx_t u[3][3], x[3][3], m1[3][3], y[3][3];
    cplx_t c, w;
    longint e[9], r[9], sr, si;
    longint co, so, ce, se;
    int n;
    pix_t res;
    res = '0;
    if (!pv) return res;
    co = clamp_trig(shadow_co);
    so = clamp_trig(shadow_so);
    ce = clamp_trig(shadow_ce);
    se = clamp_trig(shadow_se);
    for (int k = 0; k < 9; k++) begin
      e[k] = longint'($signed(px[k]));
      r[k] = 0;
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        u[a][b] = cx(0, 0);
        x[a][b] = cx(0, 0);
      end
    if (shadow_mode == pbc_pkg::MODE_SINCLAIR) begin
      n = 2;
      u[0][0] = cx(qmul(co, ce), -qmul(so, se));
      u[0][1] = cx(-qmul(so, ce), qmul(co, se));
      u[1][0] = cx(qmul(so, ce), qmul(co, se));
      u[1][1] = cx(qmul(co, ce), qmul(so, se));
      x[0][0] = cx(e[0], e[1]);
      x[0][1] = cx(e[2], e[3]);
      x[1][0] = cx(e[4], e[5]);
      x[1][1] = cx(e[6], e[7]);
    end else begin
      n = 3;
      u[0][0] = cx(ce, 0);
      u[0][1] = cx(0, -qmul(se, so));
      u[0][2] = cx(0, qmul(se, co));
      u[1][1] = cx(co, 0);
      u[1][2] = cx(so, 0);
      u[2][0] = cx(0, se);
      u[2][1] = cx(-qmul(ce, so), 0);
      u[2][2] = cx(qmul(ce, co), 0);
      x[0][0] = cx(e[0], 0);
      x[0][1] = cx(e[1], e[2]);
      x[0][2] = cx(e[3], e[4]);
      x[1][1] = cx(e[5], 0);
      x[1][2] = cx(e[6], e[7]);
      x[2][2] = cx(e[8], 0);
      x[1][0] = cx(e[1], -e[2]);
      x[2][0] = cx(e[3], -e[4]);
      x[2][1] = cx(e[6], -e[7]);
    end
    for (int a = 0; a < n; a++)
      for (int k = 0; k < n; k++) begin
        sr = 0;
        si = 0;
        for (int i = 0; i < n; i++) begin
          c = ctimes(x[i][k], n == 2 ? u[i][a] : u[a][i]);
          sr += c.re;
          si += c.im;
        end
        m1[a][k] = cx(clip(sr, SW + 4), clip(si, SW + 4));
      end
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++) begin
        sr = 0;
        si = 0;
        for (int k = 0; k < n; k++) begin
          w = n == 2 ? u[k][b] : cx(u[b][k].re, -u[b][k].im);
          c = ctimes(m1[a][k], w);
          sr += c.re;
          si += c.im;
        end
        y[a][b] = cx(clip(sr, SW), clip(si, SW));
      end
    if (n == 2) begin
      r[0] = y[0][0].re; r[1] = y[0][0].im;
      r[2] = y[0][1].re; r[3] = y[0][1].im;
      r[4] = y[1][0].re; r[5] = y[1][0].im;
      r[6] = y[1][1].re; r[7] = y[1][1].im;
    end else begin
      r[0] = y[0][0].re;
      r[1] = y[0][1].re; r[2] = y[0][1].im;
      r[3] = y[0][2].re; r[4] = y[0][2].im;
      r[5] = y[1][1].re;
      r[6] = y[1][2].re; r[7] = y[1][2].im;
      r[8] = y[2][2].re;
    end
    for (int k = 0; k < 9; k++) res[k] = SW'(r[k]);
    return res;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    pix_t got, want;
    int held;
    out_ready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold off the result side so the pipeline fills and stalls its input
        out_ready = 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else begin
        out_ready = ($urandom_range(99) >= out_idle_pct);
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {out_i, out_h, out_g, out_f, out_e, out_d, out_c, out_b, out_a};
        if (pending_pixels.size() == 0) begin
          report_mismatch("result beat with no pixel outstanding");
        end else begin
          want = pending_pixels.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want[k])
              report_mismatch($sformatf("field %0d got %h want %h", k, got[k], want[k]));
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_pixel(logic pv, pix_t px);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_vld = 1'b0;
      @(negedge clk);
    end
    in_vld = 1'b1;
    in_pixel_valid = pv;
    in_elems = px;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(predict_pixel(pv, px));
  endtask

  task automatic drain();
    @(negedge clk);
    in_vld = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (pbc_pkg::NUM_STAGES + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [pbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pbc_pkg::TRIG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      pbc_pkg::CFG_DATA_MODE:  shadow_mode = pbc_pkg::mode_t'(val[0]);
      pbc_pkg::CFG_COS_ORIENT: shadow_co = val;
      pbc_pkg::CFG_SIN_ORIENT: shadow_so = val;
      pbc_pkg::CFG_COS_ELLIP:  shadow_ce = val;
      pbc_pkg::CFG_SIN_ELLIP:  shadow_se = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_angles(logic [pbc_pkg::TRIG_W-1:0] co, logic [pbc_pkg::TRIG_W-1:0] so,
                            logic [pbc_pkg::TRIG_W-1:0] ce, logic [pbc_pkg::TRIG_W-1:0] se);
    write_reg(pbc_pkg::CFG_COS_ORIENT, co);
    write_reg(pbc_pkg::CFG_SIN_ORIENT, so);
    write_reg(pbc_pkg::CFG_COS_ELLIP, ce);
    write_reg(pbc_pkg::CFG_SIN_ELLIP, se);
  endtask

  function automatic logic [pbc_pkg::TRIG_W-1:0] rand_trig();
    if ($urandom_range(9) == 0) return pbc_pkg::TRIG_W'($urandom);
    return pbc_pkg::TRIG_W'($signed($urandom_range(131072)) - 65536);
  endfunction

  function automatic pix_t rand_pixel();
    pix_t px;
    for (int k = 0; k < 9; k++)
      case ($urandom_range(3))
        0: px[k] = $urandom;
        1: px[k] = $urandom_range(1) ? S_MAX - $urandom_range(255) : S_MIN + $urandom_range(255);
        default: px[k] = SW'($signed($urandom_range(1 << 24)) - (1 << 23));
      endcase
    return px;
  endfunction

  function automatic pix_t fill(logic [SW-1:0] v);
    pix_t px;
    for (int k = 0; k < 9; k++) px[k] = v;
    return px;
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    // identity basis straight after reset
    send_pixel(1'b1, rand_pixel());
    send_pixel(1'b1, fill(S_MAX));
    drain();
  endtask

  task automatic test_sinclair_directed();
    write_reg(pbc_pkg::CFG_DATA_MODE, 18'(pbc_pkg::MODE_SINCLAIR));
    set_angles(18'd46341, 18'd46341, 18'd56756, TRIG_NEG_ONE + 18'd32768);
    send_pixel(1'b1, fill(S_MAX));
    send_pixel(1'b1, fill(S_MIN));
    send_pixel(1'b1, fill('0));
    send_pixel(1'b1, {S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX});
    send_pixel(1'b0, fill(S_MAX));
    send_pixel(1'b1, rand_pixel());
    drain();
  endtask

  task automatic test_coherency_directed();
    write_reg(pbc_pkg::CFG_DATA_MODE, 18'(pbc_pkg::MODE_COHERENCY));
    send_pixel(1'b1, fill(S_MAX));
    send_pixel(1'b1, fill(S_MIN));
    send_pixel(1'b0, rand_pixel());
    send_pixel(1'b1, {S_MAX, 32'h0, 32'h10000, 32'h0, S_MIN, 32'h0, 32'h0, 32'h0, S_MAX});
    send_pixel(1'b1, rand_pixel());
    drain();
  endtask

  task automatic test_trig_extremes();
    // out-of-range registers clamp to +-1.0; spare index writes are ignored
    set_angles(TRIG_RAW_MAX, TRIG_RAW_MIN, TRIG_NEG_ONE, TRIG_POS_ONE);
    write_reg(CFG_IDX_SPARE, TRIG_RAW_MAX);
    send_pixel(1'b1, fill(S_MAX));
    send_pixel(1'b1, rand_pixel());
    drain();
    write_reg(pbc_pkg::CFG_DATA_MODE, 18'(pbc_pkg::MODE_SINCLAIR));
    set_angles(TRIG_NEG_ONE, TRIG_POS_ONE, TRIG_RAW_MIN, TRIG_RAW_MAX);
    send_pixel(1'b1, fill(S_MIN));
    send_pixel(1'b1, rand_pixel());
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int blk = 0; blk < 4; blk++) begin
      write_reg(pbc_pkg::CFG_DATA_MODE, 18'($urandom_range(1)));
      set_angles(rand_trig(), rand_trig(), rand_trig(), rand_trig());
      for (int k = 0; k < n_items / 4; k++)
        send_pixel($urandom_range(15) != 0, rand_pixel());
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) send_pixel(1'b1, rand_pixel());
    drain();
  endtask

  initial begin
    errors = 0;
    hold_req = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pbc_pkg::CFG_DATA_MODE;
    cfg_wdata = '0;
    in_vld = 1'b0;
    in_pixel_valid = 1'b0;
    in_elems = '0;
    shadow_mode = pbc_pkg::MODE_SINCLAIR;
    shadow_co = TRIG_POS_ONE;
    shadow_so = '0;
    shadow_ce = TRIG_POS_ONE;
    shadow_se = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct = 21;
    out_idle_pct = 83;
    test_reset_defaults();
    test_sinclair_directed();
    test_coherency_directed();
    test_trig_extremes();
    test_random(120);

    in_idle_pct = 83;
    out_idle_pct = 21;
    test_random(120);

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_backpressure();
    test_random(160);

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
